FILE: rtl/indexed_shift_list_macros.svh
// Assertion macros shared by the indexed shift list RTL.
`ifndef INDEXED_SHIFT_LIST_MACROS_SVH
`define INDEXED_SHIFT_LIST_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define ISL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Checked on every clock edge, reset included.
`define ISL_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("%m: assertion failed");
`else
`define ISL_ASSERT(label, clk, rst_n, prop)
`define ISL_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/isl_pkg.sv
// Types, codes and constants shared by the indexed shift list modules.
`timescale 1ns / 1ps
package isl_pkg;

	localparam int OP_W         = 3;
	localparam int INDEX_W      = 5;
	localparam int VALUE_W      = 32;
	localparam int STATUS_W     = 2;
	localparam int FIDX_W       = 4;
	localparam int COUNT_W      = 5;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [OP_W-1:0] {
		OP_GET,
		OP_FIND,
		OP_INSERT,
		OP_REMOVE,
		OP_CLEAR
	} isl_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_BAD_INDEX,
		ST_FULL,
		ST_NOT_FOUND
	} isl_status_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
	} isl_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  read_value;
		logic [FIDX_W-1:0]   found_index;
		logic [COUNT_W-1:0]  count;
	} isl_rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic               apply;
		logic               ins;
		logic               rem;
		logic               get;
		logic               find;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
	} isl_cmd_t;

endpackage

FILE: rtl/isl_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbours.
`timescale 1ns / 1ps
module isl_cell
	import isl_pkg::*;
#(
	parameter int POS = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  isl_cmd_t           cmd,
	input  logic               live,
	input  logic [VALUE_W-1:0] prev_entry,
	input  logic [VALUE_W-1:0] next_entry,
	output logic [VALUE_W-1:0] entry,
	output logic               hit
);

	logic [VALUE_W-1:0] entry_q;
	logic               hit_q;
	logic               above_idx;
	logic               at_idx;

	assign above_idx = POS > int'(cmd.index);
	assign at_idx    = POS == int'(cmd.index);

	// An insert takes the left neighbour above the index; a remove takes the right one at and above it.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (above_idx) begin
				entry_q <= prev_entry;
			end else if (at_idx) begin
				entry_q <= cmd.value;
			end
		end else if (cmd.rem && (above_idx || at_idx)) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.apply) begin
			hit_q <= (cmd.get && at_idx) || (cmd.find && live && entry_q == cmd.value);
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

FILE: rtl/isl_tree.sv
// Registered priority tree that picks the lowest flagged cell and its entry.
`timescale 1ns / 1ps
module isl_tree
	import isl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic [DEPTH-1:0]                hit,
	input  logic [DEPTH-1:0][VALUE_W-1:0]   data,
	output logic                            root_hit,
	output logic [$clog2(DEPTH)-1:0]        root_idx,
	output logic [VALUE_W-1:0]              root_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int N  = 1 << IW;

	typedef struct packed {
		logic               hit;
		logic [IW-1:0]      idx;
		logic [VALUE_W-1:0] data;
	} node_t;

	node_t leaf_n [N];
	node_t node_q [1:N-1];

	for (genvar j = 0; j < N; j++) begin : g_leaf
		if (j < DEPTH) begin : g_used
			assign leaf_n[j] = '{hit: hit[j], idx: IW'(j), data: data[j]};
		end else begin : g_pad
			assign leaf_n[j] = '0;
		end
	end

	// The left child wins whenever it holds a flagged cell.
	for (genvar k = 1; k < N; k++) begin : g_node
		if (2 * k >= N) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[k] <= leaf_n[2*k-N].hit ? leaf_n[2*k-N] : leaf_n[2*k+1-N];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[k] <= node_q[2*k].hit ? node_q[2*k] : node_q[2*k+1];
			end
		end
	end

	assign root_hit  = node_q[1].hit;
	assign root_idx  = node_q[1].idx;
	assign root_data = node_q[1].data;

endmodule

FILE: rtl/indexed_shift_list.sv
// Top level of the indexed shift list: control, cell chain and result register.
`timescale 1ns / 1ps
`include "indexed_shift_list_macros.svh"
// An ordered list of up to DEPTH 32-bit values held in a chain of cells, one
// entry per cell. A request is get, find, insert, remove or clear, and each
// request gives exactly one response carrying a status, the value read by a
// get, the lowest matching position found by a find, and the entry count after
// the request. Insert and remove shift the cells above the index by one place
// in the cycle the request transfer happens, every cell taking its neighbour's
// entry at once. Get and find flag the wanted cells in that same cycle, and a
// registered priority tree of L = ceil(log2(DEPTH)) levels then picks the
// lowest flagged cell. The block works on one request at a time: once a request
// is transferred, no new one is taken until its response has been loaded into
// the output register, a load held back while an earlier response waits there.
// The response is held in an output register, so a new request is taken while
// an earlier response still waits to be transferred. Bad indexes and inserts
// into a full list return an error status and leave the list unchanged;
// unused operation codes return an ok status and change nothing.
module indexed_shift_list
	import isl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  isl_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output isl_rsp_t rsp
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int IW  = $clog2(DEPTH);
	localparam int LAT = IW;
	localparam int WW  = $clog2(LAT + 1);

	typedef enum logic {
		S_IDLE,
		S_WAIT
	} state_t;

	state_t                  state_q;
	logic [WW-1:0]           wait_q;
	logic [CW-1:0]           count_q;
	logic                    pend_get_q;
	logic                    pend_find_q;
	isl_status_t             pend_status_q;
	isl_rsp_t                rsp_q;
	logic                    rsp_valid_q;

	logic                    accept;
	isl_cmd_t                cmd;
	isl_status_t             status_next;
	logic [CW-1:0]           count_next;
	logic                    full;

	logic [DEPTH-1:0][VALUE_W-1:0] ent;
	logic [DEPTH-1:0]              hit;
	logic [DEPTH-1:0]              live;

	logic                    root_hit;
	logic [IW-1:0]           root_idx;
	logic [VALUE_W-1:0]      root_data;
	logic                    result_ready;
	logic                    get_done;
	isl_status_t             final_status;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(DEPTH));

	// Decode the request against the current count. The shift commands are
	// only raised for a request that is transferred and passes its checks.
	always_comb begin
		cmd         = '0;
		cmd.apply   = accept;
		cmd.index   = req.index;
		cmd.value   = req.value;
		status_next = ST_OK;
		count_next  = count_q;
		unique case (req.op)
			OP_GET: begin
				cmd.get = 1'b1;
				if (int'(req.index) >= int'(count_q)) begin
					status_next = ST_BAD_INDEX;
				end
			end
			OP_FIND: begin
				cmd.find = 1'b1;
			end
			OP_INSERT: begin
				if (int'(req.index) > int'(count_q)) begin
					status_next = ST_BAD_INDEX;
				end else if (full) begin
					status_next = ST_FULL;
				end else begin
					cmd.ins    = accept;
					count_next = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (int'(req.index) >= int'(count_q)) begin
					status_next = ST_BAD_INDEX;
				end else begin
					cmd.rem    = accept;
					count_next = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
			end
		endcase
	end

	// The chain of cells. The end cells see their own entry as the missing
	// neighbour; what they shift in there lies beyond the count.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [VALUE_W-1:0] prev_entry;
		logic [VALUE_W-1:0] next_entry;

		if (g == 0) begin : g_first
			assign prev_entry = ent[g];
		end else begin : g_prev
			assign prev_entry = ent[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign next_entry = ent[g];
		end else begin : g_next
			assign next_entry = ent[g+1];
		end

		assign live[g] = (g < int'(count_q));

		isl_cell #(
			.POS (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.live       (live[g]),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (ent[g]),
			.hit        (hit[g])
		);
	end

	isl_tree #(
		.DEPTH (DEPTH)
	) u_tree (
		.clk       (clk),
		.hit       (hit),
		.data      (ent),
		.root_hit  (root_hit),
		.root_idx  (root_idx),
		.root_data (root_data)
	);

	// The tree output is settled once the wait count has run out, and it is
	// loaded as soon as the output register is free or being emptied.
	assign result_ready = (state_q == S_WAIT) && (wait_q == '0) &&
		(!rsp_valid_q || rsp_ready);
	assign final_status = pend_find_q ? (root_hit ? ST_OK : ST_NOT_FOUND) : pend_status_q;
	assign get_done     = result_ready && pend_get_q && (pend_status_q == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wait_q        <= '0;
			count_q       <= '0;
			pend_get_q    <= 1'b0;
			pend_find_q   <= 1'b0;
			pend_status_q <= ST_OK;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			// The output register is full after a load, and stays full until
			// its transfer happens.
			rsp_valid_q <= result_ready || (rsp_valid_q && !rsp_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q       <= S_WAIT;
						wait_q        <= WW'(LAT);
						count_q       <= count_next;
						pend_get_q    <= cmd.get;
						pend_find_q   <= cmd.find;
						pend_status_q <= status_next;
					end
				end
				S_WAIT: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - 1'b1;
					end else if (result_ready) begin
						state_q           <= S_IDLE;
						rsp_q.status      <= final_status;
						rsp_q.read_value  <= (pend_get_q && pend_status_q == ST_OK) ?
							root_data : '0;
						rsp_q.found_index <= (pend_find_q && root_hit) ?
							FIDX_W'(root_idx) : '0;
						rsp_q.count       <= COUNT_W'(count_q);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ISL_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH))
	`ISL_ASSERT(a_one_at_a_time, clk, arst_n, accept |=> !req_ready)
	`ISL_ASSERT(a_get_hits, clk, arst_n, get_done |-> root_hit)
	`ISL_ASSERT(a_insert_grows, clk, arst_n, cmd.ins |=> count_q == $past(count_q) + 1'b1)

endmodule
